// ----- rtl/kdlp_pkg.sv -----
// Shared types and constants for the key debounce and long-press detector.
`timescale 1ns / 1ps

package kdlp_pkg;

    localparam int unsigned NUM_KEYS  = 6;
    localparam int unsigned KEY_W     = 3;
    localparam int unsigned CODE_W    = 3;
    localparam int unsigned DEB_W     = 8;
    localparam int unsigned LONG_W    = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 8;

    typedef logic [KEY_W-1:0]  key_idx_t;
    typedef logic [CODE_W-1:0] event_code_t;

    typedef enum logic {
        CFG_DEBOUNCE_TICKS   = 1'b0,
        CFG_LONG_PRESS_TICKS = 1'b1
    } cfg_index_t;

    localparam key_idx_t KEY_IDX_LX = 3'd4;
    localparam key_idx_t KEY_IDX_RX = 3'd5;

    localparam event_code_t EV_LEFT_X       = 3'd4;
    localparam event_code_t EV_LEFT_X_LONG  = 3'd5;
    localparam event_code_t EV_RIGHT_X      = 3'd6;
    localparam event_code_t EV_RIGHT_X_LONG = 3'd7;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd10;
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd1000;

    function automatic event_code_t code_for(input key_idx_t k, input logic is_long);
        event_code_t code;
        if (k == KEY_IDX_LX) begin
            code = is_long ? EV_LEFT_X_LONG : EV_LEFT_X;
        end else if (k == KEY_IDX_RX) begin
            code = is_long ? EV_RIGHT_X_LONG : EV_RIGHT_X;
        end else begin
            code = event_code_t'(k);
        end
        return code;
    endfunction

endpackage

// ----- rtl/key_debounce_long_press.sv -----
// Key debounce with long-press detection: one beat in per timer tick.
// The releasing beat registers its event, in the skid entry if the output is held.
// Throughput: one input beat per cycle; a two-entry output buffer keeps input
// flowing while one event waits, so s_tready drops only with both entries full.
// Reset (aresetn low, synchronous): idle phase, empty output buffer,
// debounce_ticks = 10, long_press_ticks = 1000.
`timescale 1ns / 1ps

module key_debounce_long_press
    import kdlp_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [5:0] key_levels, [7:6] zero

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [2:0] event_code, [7:3] zero

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_WAIT     = 2'd2
    } phase_t;

    logic [DEB_W-1:0]       deb_reg;
    logic [LONG_W-1:0]      long_reg;
    phase_t                 phase_reg, phase_next;
    key_idx_t               key_reg, key_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;

    logic                   out_valid_reg, skid_valid_reg;
    event_code_t            out_code_reg, skid_code_reg;

    logic [NUM_KEYS-1:0]    levels;
    logic                   in_beat;
    logic                   out_beat;
    logic                   emit;
    event_code_t            emit_code;
    logic [COUNT_WIDTH-1:0] hold_inc;
    logic                   key_found;
    key_idx_t               key_first;
    logic                   tracked_down;

    assign levels    = s_tdata[NUM_KEYS-1:0];
    assign s_tready  = !skid_valid_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign out_beat  = out_valid_reg && m_tready;
    assign m_tdata   = {{(M_TDATA_W-CODE_W){1'b0}}, out_code_reg};
    assign cfg_ready = 1'b1;

    assign hold_inc     = (hold_reg == COUNT_MAX) ? hold_reg : hold_reg + 1'b1;
    assign tracked_down = !levels[key_reg];

    always_comb begin
        key_found = 1'b0;
        key_first = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (!levels[i]) begin
                key_found = 1'b1;
                key_first = key_idx_t'(i);
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        key_next   = key_reg;
        hold_next  = hold_reg;
        emit       = 1'b0;
        emit_code  = code_for(key_reg, CMP_W'(hold_inc) > CMP_W'(long_reg));
        unique case (phase_reg)
            PH_DEBOUNCE: begin
                hold_next = hold_inc;
                if (hold_inc >= COUNT_WIDTH'(deb_reg)) begin
                    phase_next = tracked_down ? PH_WAIT : PH_IDLE;
                end
            end
            PH_WAIT: begin
                hold_next = hold_inc;
                if (!tracked_down) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (key_found) begin
                    key_next   = key_first;
                    hold_next  = '0;
                    phase_next = PH_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg        <= DEB_RESET;
            long_reg       <= LONG_RESET;
            phase_reg      <= PH_IDLE;
            key_reg        <= '0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_DEBOUNCE_TICKS:   deb_reg  <= cfg_data[DEB_W-1:0];
                    CFG_LONG_PRESS_TICKS: long_reg <= cfg_data[LONG_W-1:0];
                    default: ;
                endcase
            end

            if (in_beat) begin
                phase_reg <= phase_next;
                key_reg   <= key_next;
                hold_reg  <= hold_next;
            end

            // drain skid first; a push can only land while skid is empty
            if (skid_valid_reg) begin
                if (out_beat) begin
                    out_code_reg   <= skid_code_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (out_valid_reg && !out_beat) begin
                if (in_beat && emit) begin
                    skid_code_reg  <= emit_code;
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                out_valid_reg <= in_beat && emit;
                out_code_reg  <= emit_code;
            end
        end
    end

endmodule
